[design/tplf_pkg.sv]
// ----------------------------------------------------------------------------
// tplf_pkg
// Shared types and constants for the TCP payload length filter.
// ----------------------------------------------------------------------------
package tplf_pkg;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [15:0] LIMIT_RESET    = 16'd40;

	// byte positions inside the frame
	localparam logic [15:0] POS_ETYPE_HI   = 16'd12;
	localparam logic [15:0] POS_ETYPE_LO   = 16'd13;
	localparam logic [15:0] POS_IHL        = 16'd14;
	localparam logic [15:0] POS_TLEN_HI    = 16'd16;
	localparam logic [15:0] POS_TLEN_LO    = 16'd17;
	localparam logic [15:0] POS_PROTO      = 16'd23;
	localparam logic [15:0] POS_DOFF_BASE  = 16'd26;
	localparam logic [15:0] POS_MAX        = 16'hFFFF;

	// frame length thresholds, expressed on the position of the last byte
	localparam logic [15:0] LAST_POS_ETH   = 16'd13;
	localparam logic [15:0] LAST_POS_IP    = 16'd33;

	typedef enum logic [2:0] {
		CLS_SHORT_ETH = 3'd0,
		CLS_NOT_IPV4  = 3'd1,
		CLS_SHORT_IP  = 3'd2,
		CLS_NOT_TCP   = 3'd3,
		CLS_SHORT_TCP = 3'd4,
		CLS_CHECKED   = 3'd5
	} class_t;

	// header fields of one frame as seen at its last byte
	typedef struct packed {
		logic [15:0] last_pos;
		logic [15:0] ether_kind;
		logic [3:0]  ip_header_words;
		logic [15:0] ip_total_length;
		logic [7:0]  ip_protocol;
		logic [3:0]  tcp_header_words;
	} frame_summary_t;

endpackage

[design/tplf_capture.sv]
// ----------------------------------------------------------------------------
// tplf_capture
// Byte position counter and header field capture for one frame.
// ----------------------------------------------------------------------------
module tplf_capture
	import tplf_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           beat_en,
	input  logic [7:0]     frame_byte,
	input  logic           last_byte,
	output frame_summary_t summary
);

	logic [15:0] byte_offset_q;
	logic [15:0] ether_kind_q;
	logic [3:0]  ihl_q;
	logic [15:0] total_len_q;
	logic [7:0]  protocol_q;
	logic [3:0]  doff_q;

	logic [15:0] doff_pos;

	// header fields including the current beat
	always_comb begin
		doff_pos = POS_DOFF_BASE + {10'd0, ihl_q, 2'b00};
		summary.last_pos         = byte_offset_q;
		summary.ether_kind       = ether_kind_q;
		summary.ip_header_words  = ihl_q;
		summary.ip_total_length  = total_len_q;
		summary.ip_protocol      = protocol_q;
		summary.tcp_header_words = doff_q;
		if (byte_offset_q == POS_ETYPE_HI) summary.ether_kind[15:8] = frame_byte;
		if (byte_offset_q == POS_ETYPE_LO) summary.ether_kind[7:0] = frame_byte;
		if (byte_offset_q == POS_IHL) summary.ip_header_words = frame_byte[3:0];
		if (byte_offset_q == POS_TLEN_HI) summary.ip_total_length[15:8] = frame_byte;
		if (byte_offset_q == POS_TLEN_LO) summary.ip_total_length[7:0] = frame_byte;
		if (byte_offset_q == POS_PROTO) summary.ip_protocol = frame_byte;
		if (byte_offset_q == doff_pos) summary.tcp_header_words = frame_byte[7:4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q <= '0;
			ether_kind_q  <= '0;
			ihl_q         <= '0;
			total_len_q   <= '0;
			protocol_q    <= '0;
			doff_q        <= '0;
		end else if (beat_en) begin
			if (last_byte) begin
				byte_offset_q <= '0;
				ether_kind_q  <= '0;
				ihl_q         <= '0;
				total_len_q   <= '0;
				protocol_q    <= '0;
				doff_q        <= '0;
			end else begin
				// counter sticks at its top value on very long frames
				if (byte_offset_q != POS_MAX) byte_offset_q <= byte_offset_q + 16'd1;
				ether_kind_q <= summary.ether_kind;
				ihl_q        <= summary.ip_header_words;
				total_len_q  <= summary.ip_total_length;
				protocol_q   <= summary.ip_protocol;
				doff_q       <= summary.tcp_header_words;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		beat_en && last_byte |=> byte_offset_q == '0 && ihl_q == '0)
		else $error("frame state not cleared after last beat");

	a_offset_counts: assert property (@(posedge clk) disable iff (!arst_n)
		beat_en && !last_byte && byte_offset_q != POS_MAX
		|=> byte_offset_q == $past(byte_offset_q) + 16'd1)
		else $error("byte offset did not advance");

endmodule

[design/tcp_payload_length_filter.sv]
// ----------------------------------------------------------------------------
// tcp_payload_length_filter
// Per-frame TCP payload length check on a byte stream.
// ----------------------------------------------------------------------------
// Frames enter one byte per beat, starting at the Ethernet header, with tlast
// on the final byte. The block accepts one beat every cycle; the only stall is
// back-pressure from the verdict output. One verdict beat leaves per frame,
// registered first as the captured header summary and then as the verdict.
// A frame is dropped only if it is IPv4/TCP, long enough for both headers,
// and total length minus both header lengths exceeds payload_limit (reset 40).
// The user must write payload_limit through cfg_wr_en / cfg_wr_data only while
// no frame is in flight; the block itself does not enforce this.
module tcp_payload_length_filter
	import tplf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,   // payload_limit
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] frame_byte
	input  logic        s_axis_tlast,  // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // [0] drop, [3:1] class_code, [19:4] payload_bytes
);

	logic           advance;
	logic           in_beat;
	frame_summary_t summary;

	logic [15:0]    limit_q;
	logic           valid_s1;
	frame_summary_t summ_s1;
	logic           valid_s2;
	logic           drop_s2;
	class_t         class_s2;
	logic [15:0]    payload_s2;

	logic [6:0]     hdr_bytes;
	logic [15:0]    ip_end_pos;
	logic           drop_d;
	class_t         class_d;
	logic [15:0]    payload_d;

	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = advance;
	assign in_beat       = s_axis_tvalid && advance;

	tplf_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_en    (in_beat),
		.frame_byte (s_axis_tdata),
		.last_byte  (s_axis_tlast),
		.summary    (summary)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_beat && s_axis_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat && s_axis_tlast) summ_s1 <= summary;
	end

	// verdict from the captured header summary
	always_comb begin
		hdr_bytes  = {1'b0, summ_s1.ip_header_words, 2'b00}
			+ {1'b0, summ_s1.tcp_header_words, 2'b00};
		// tcp header must end inside the frame: last position >= 33 + 4*ihl
		ip_end_pos = LAST_POS_IP + {10'd0, summ_s1.ip_header_words, 2'b00};
		drop_d     = 1'b0;
		payload_d  = '0;
		priority if (summ_s1.last_pos < LAST_POS_ETH) begin
			class_d = CLS_SHORT_ETH;
		end else if (summ_s1.ether_kind != ETHERTYPE_IPV4) begin
			class_d = CLS_NOT_IPV4;
		end else if (summ_s1.last_pos < LAST_POS_IP) begin
			class_d = CLS_SHORT_IP;
		end else if (summ_s1.ip_protocol != PROTO_TCP) begin
			class_d = CLS_NOT_TCP;
		end else if (summ_s1.last_pos < ip_end_pos) begin
			class_d = CLS_SHORT_TCP;
		end else begin
			class_d = CLS_CHECKED;
			if (summ_s1.ip_total_length > {9'd0, hdr_bytes})
				payload_d = summ_s1.ip_total_length - {9'd0, hdr_bytes};
			drop_d = payload_d > limit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			drop_s2    <= drop_d;
			class_s2   <= class_d;
			payload_s2 <= payload_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'd0, payload_s2, class_s2, drop_s2};

	a_last_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && s_axis_tlast |=> valid_s1)
		else $error("last beat did not produce a summary");

	a_drop_only_checked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && drop_s2 |-> class_s2 == CLS_CHECKED && payload_s2 != '0)
		else $error("drop verdict without a checked payload");

endmodule

[verif/tcp_payload_length_filter_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_payload_length_filter_monitor
// Watches the frame byte stream, predicts each verdict and checks the output.
// ----------------------------------------------------------------------------
// Keeps its own copy of the header capture state and of payload_limit (taken
// from the configuration port), queues one predicted verdict per frame and
// compares every verdict beat with the oldest one, field by field.
module tcp_payload_length_filter_monitor
	import tplf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
	input  logic        s_axis_tlast,   // last_byte
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,   // [0] drop, [3:1] class_code, [19:4] payload_bytes
	output int          mismatches,
	output int          verdicts_pending,
	output int          verdicts_seen,
	output int          drops_seen,
	output logic [5:0]  classes_seen
);

	localparam int ETH_HDR_LEN = 14;
	localparam int IP_MIN_LEN  = 20;
	localparam int TCP_MIN_LEN = 20;

	typedef struct packed {
		logic        drop;
		class_t      cls;
		logic [15:0] payload;
	} verdict_t;

	verdict_t    expected_verdicts[$];
	verdict_t    oldest;
	int          frame_len;
	logic [15:0] limit_copy;
	logic [15:0] byte_pos;
	logic [15:0] ether_kind;
	logic [3:0]  ip_header_words;
	logic [15:0] ip_total_length;
	logic [7:0]  ip_protocol;
	logic [3:0]  tcp_header_words;

	// verdict for the frame whose last byte has just been captured
	function automatic verdict_t judge_frame(input int len);
		verdict_t v;
		int hdrs;
		v.drop = 1'b0;
		v.payload = '0;
		hdrs = 4 * int'(ip_header_words) + 4 * int'(tcp_header_words);
		if (len < ETH_HDR_LEN)
			v.cls = CLS_SHORT_ETH;
		else if (ether_kind != ETHERTYPE_IPV4)
			v.cls = CLS_NOT_IPV4;
		else if (len < ETH_HDR_LEN + IP_MIN_LEN)
			v.cls = CLS_SHORT_IP;
		else if (ip_protocol != PROTO_TCP)
			v.cls = CLS_NOT_TCP;
		else if (len < ETH_HDR_LEN + 4 * int'(ip_header_words) + TCP_MIN_LEN)
			v.cls = CLS_SHORT_TCP;
		else begin
			v.cls = CLS_CHECKED;
			if (int'(ip_total_length) > hdrs)
				v.payload = 16'(int'(ip_total_length) - hdrs);
			v.drop = (v.payload != 0) && (v.payload > limit_copy);
		end
		return v;
	endfunction

	task automatic flag_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		mismatches++;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_verdicts.delete();
			limit_copy = LIMIT_RESET;
			byte_pos = '0;
			ether_kind = '0;
			ip_header_words = '0;
			ip_total_length = '0;
			ip_protocol = '0;
			tcp_header_words = '0;
			mismatches = 0;
			verdicts_pending = 0;
			verdicts_seen = 0;
			drops_seen = 0;
			classes_seen = '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				verdicts_seen++;
				if (m_axis_tdata[0] === 1'b1)
					drops_seen++;
				if (m_axis_tdata[3:1] < 3'd6)
					classes_seen[m_axis_tdata[3:1]] = 1'b1;
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					$display("%0t: verdict beat with no frame outstanding, expected none, actual %h",
						$time, m_axis_tdata);
				end else begin
					oldest = expected_verdicts.pop_front();
					if (m_axis_tdata[0] !== oldest.drop)
						flag_field("drop", 16'(oldest.drop), 16'(m_axis_tdata[0]));
					if (m_axis_tdata[3:1] !== oldest.cls)
						flag_field("class_code", 16'(oldest.cls), 16'(m_axis_tdata[3:1]));
					if (m_axis_tdata[19:4] !== oldest.payload)
						flag_field("payload_bytes", oldest.payload, m_axis_tdata[19:4]);
					if (m_axis_tdata[23:20] !== 4'b0)
						flag_field("tdata padding", 16'h0, 16'(m_axis_tdata[23:20]));
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				frame_len = int'(byte_pos) + 1;
				if (byte_pos == POS_ETYPE_HI) ether_kind[15:8] = s_axis_tdata;
				if (byte_pos == POS_ETYPE_LO) ether_kind[7:0] = s_axis_tdata;
				if (byte_pos == POS_IHL) ip_header_words = s_axis_tdata[3:0];
				if (byte_pos == POS_TLEN_HI) ip_total_length[15:8] = s_axis_tdata;
				if (byte_pos == POS_TLEN_LO) ip_total_length[7:0] = s_axis_tdata;
				if (byte_pos == POS_PROTO) ip_protocol = s_axis_tdata;
				// data offset sits 12 bytes into the tcp header, wherever ihl puts it
				if (byte_pos == POS_DOFF_BASE + (16'(ip_header_words) << 2))
					tcp_header_words = s_axis_tdata[7:4];
				if (byte_pos != POS_MAX)
					byte_pos = byte_pos + 16'd1;
				if (s_axis_tlast) begin
					expected_verdicts.push_back(judge_frame(frame_len));
					byte_pos = '0;
					ether_kind = '0;
					ip_header_words = '0;
					ip_total_length = '0;
					ip_protocol = '0;
					tcp_header_words = '0;
				end
			end

			// register takes effect after this edge
			if (cfg_wr_en)
				limit_copy = cfg_wr_data;

			verdicts_pending = expected_verdicts.size();
		end
	end

endmodule

[verif/tcp_payload_length_filter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_payload_length_filter_test
// Stimulus and verdict for the TCP payload length filter.
// ----------------------------------------------------------------------------
// Sends crafted corner frames and random IPv4/TCP frames mixed with noise,
// under bursty input and a patterned output stall, across several
// payload_limit settings. The monitor does all checking.
module tcp_payload_length_filter_test;
	import tplf_pkg::*;

	localparam int LONG_HOLD_CYCLES = 150;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;

	int          mismatches;
	int          verdicts_pending;
	int          verdicts_seen;
	int          drops_seen;
	logic [5:0]  classes_seen;

	logic [7:0]  frame_buf[$];
	logic [15:0] limit_now;
	int          burst_left;
	int          bytes_sent;
	int          frames_sent;
	bit          sender_steady;
	bit          long_hold_req;

	tcp_payload_length_filter dut (.*);

	tcp_payload_length_filter_monitor verdict_monitor (.*);

	always #5 clk = ~clk;

	// one beat; bursts of random length with gaps between them
	task automatic put_byte(input logic [7:0] b, input logic is_last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!sender_steady) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= is_last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_crafted_frame(input int len, input logic [15:0] etype,
			input logic [7:0] vihl, input logic [15:0] tlen, input logic [7:0] proto,
			input logic [7:0] doff_byte);
		int doff_at;
		logic [7:0] b;
		doff_at = int'(POS_DOFF_BASE) + 4 * int'(vihl[3:0]);
		frame_buf.delete();
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (i == int'(POS_ETYPE_HI)) b = etype[15:8];
			if (i == int'(POS_ETYPE_LO)) b = etype[7:0];
			if (i == int'(POS_IHL)) b = vihl;
			if (i == int'(POS_TLEN_HI)) b = tlen[15:8];
			if (i == int'(POS_TLEN_LO)) b = tlen[7:0];
			if (i == int'(POS_PROTO)) b = proto;
			if (i == doff_at) b = doff_byte;
			frame_buf.push_back(b);
		end
		for (int i = 0; i < frame_buf.size(); i++)
			put_byte(frame_buf[i], i == frame_buf.size() - 1);
		frames_sent++;
	endtask

	// mostly well-formed tcp frames near the limit, some noise and broken headers
	task automatic random_frame();
		int kind;
		int ihl;
		int doff;
		int len;
		int payload;
		int total;
		logic [15:0] etype;
		logic [7:0] proto;
		kind = $urandom_range(0, 9);
		ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
		doff = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
		case ($urandom_range(0, 3))
			0: payload = $urandom_range(0, 100);
			1: payload = int'(limit_now) + int'($urandom_range(0, 2)) - 1;
			2: payload = $urandom_range(0, 65535);
			default: payload = -int'($urandom_range(0, 60));
		endcase
		total = 4 * ihl + 4 * doff + payload;
		if (total < 0) total = 0;
		if (total > 65535) total = 65535;
		len = 34 + 4 * ihl + $urandom_range(0, 6);
		etype = ETHERTYPE_IPV4;
		proto = PROTO_TCP;
		if (kind >= 7) begin
			len = $urandom_range(1, 40 + 4 * ihl);
			if ($urandom_range(0, 1)) etype = 16'($urandom);
			if ($urandom_range(0, 1)) proto = 8'($urandom);
		end
		send_crafted_frame(len, etype, {4'($urandom), 4'(ihl)}, 16'(total), proto,
			{4'(doff), 4'($urandom)});
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		wait (verdicts_pending == 0);
		@(negedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		wait_drained();
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		limit_now = v;
	endtask

	// receiver: rotating stall pattern, or one long hold on request
	initial begin
		int phase;
		logic [15:0] pattern;
		m_axis_tready = 1'b0;
		pattern = 16'hFFFF;
		phase = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				long_hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else begin
				if (phase == 0)
					pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
						: (16'($urandom) | 16'h0001);
				m_axis_tready <= pattern[phase];
				phase = (phase + 1) % 16;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		long_hold_req = 1'b0;
		sender_steady = 1'b0;
		burst_left = 0;
		bytes_sent = 0;
		frames_sent = 0;
		limit_now = LIMIT_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corner frames against the reset limit
		send_crafted_frame(1, ETHERTYPE_IPV4, 8'h45, 16'd100, PROTO_TCP, 8'h50);
		// last byte completes the ethertype
		send_crafted_frame(14, ETHERTYPE_IPV4, 8'h45, 16'd100, PROTO_TCP, 8'h50);
		send_crafted_frame(14, 16'h0801, 8'h45, 16'd100, PROTO_TCP, 8'h50);
		send_crafted_frame(33, ETHERTYPE_IPV4, 8'h45, 16'd100, PROTO_TCP, 8'h50);
		send_crafted_frame(34, ETHERTYPE_IPV4, 8'h45, 16'd100, 8'd17, 8'h50);
		send_crafted_frame(53, ETHERTYPE_IPV4, 8'h45, 16'd80, PROTO_TCP, 8'h50);
		// payload right at and just above the limit
		send_crafted_frame(54, ETHERTYPE_IPV4, 8'h45, 16'd80, PROTO_TCP, 8'h50);
		send_crafted_frame(54, ETHERTYPE_IPV4, 8'h45, 16'd81, PROTO_TCP, 8'h50);
		// zero payload
		send_crafted_frame(54, ETHERTYPE_IPV4, 8'h45, 16'd40, PROTO_TCP, 8'h50);
		// ihl below 5 puts the tcp header inside the ip header area
		send_crafted_frame(38, ETHERTYPE_IPV4, 8'h01, 16'd90, PROTO_TCP, 8'hF3);

		write_limit(16'd0);
		random_frame();

		// receiver holds off while one-byte frames pile up behind it
		wait_drained();
		long_hold_req = 1'b1;
		repeat (10)
			send_crafted_frame(1, ETHERTYPE_IPV4, 8'($urandom), 16'($urandom),
				PROTO_TCP, 8'($urandom));
		wait (!long_hold_req);

		write_limit(16'hFFFF);
		sender_steady = 1'b1;
		random_frame();
		sender_steady = 1'b0;

		write_limit(16'($urandom_range(1, 200)));
		random_frame();

		write_limit(LIMIT_RESET);
		random_frame();

		wait_drained();
		repeat (10) @(negedge clk);
		$display("sent %0d frames in %0d bytes, %0d verdicts checked, %0d dropped",
			frames_sent, bytes_sent, verdicts_seen, drops_seen);
		$display("classes seen %b, limits 40/0/65535/random/40 and one long output hold",
			classes_seen);
		if (mismatches == 0 && verdicts_pending == 0)
			$display("PASS tcp_payload_length_filter");
		else
			$display("FAIL tcp_payload_length_filter");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("%0t: timed out with %0d verdicts outstanding", $time, verdicts_pending);
		$display("FAIL tcp_payload_length_filter");
		$finish;
	end

endmodule
